// ----- src/lxsc_pkg.sv -----
// package: shared types, seed constants and mark table for the layered xor stream cipher
`default_nettype none
package lxsc_pkg;

  localparam logic [31:0] SeedW0 = 32'h5079_5078;
  localparam logic [31:0] SeedW1 = 32'h5874_6563;
  localparam logic [31:0] SeedW2 = 32'h746F_7230;
  localparam logic [31:0] SeedW3 = 32'h3330_3030;

  localparam logic [7:0] PosMult = 8'h79;
  localparam logic [3:0] MarkLen = 4'd13;
  localparam logic [3:0] MarkLast = MarkLen - 4'd1;

  // per-item control from the core to the keystream unit
  typedef struct packed {
    logic advance;
    logic last;
  } ks_ctrl_t;

  // mark table, last entry zero; unused indexes read as zero
  function automatic logic [7:0] mark_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h70;
      4'd1:    val = 8'h79;
      4'd2:    val = 8'h70;
      4'd3:    val = 8'h72;
      4'd4:    val = 8'h6F;
      4'd5:    val = 8'h74;
      4'd6:    val = 8'h65;
      4'd7:    val = 8'h63;
      4'd8:    val = 8'h74;
      4'd9:    val = 8'h6F;
      4'd10:   val = 8'h72;
      4'd11:   val = 8'h78;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- src/lxsc_in_if.sv -----
// interface: input item channel (message byte, key byte, end flag)
`default_nettype none
interface lxsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] key_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output key_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input key_byte, input end_of_message,
                output ready);
endinterface
`default_nettype wire

// ----- src/lxsc_out_if.sv -----
// interface: result item channel (cipher byte, final flag)
`default_nettype none
interface lxsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       final_out;

  modport source (output valid, output cipher_byte, output final_out, input ready);
  modport sink (input valid, input cipher_byte, input final_out, output ready);
endinterface
`default_nettype wire

// ----- src/layered_xor_stream_cipher_core.sv -----
// top level: layered xor stream cipher core with registered result and skid stage
//
// Takes one item per clock while the skid stage is empty (message byte, key
// byte, end flag) and returns one result item per input item, in order:
// cipher_byte = data ^ key ^ keystream ^ mark ^ (position * 0x79 mod 256).
// The same core encrypts and decrypts. An item is accepted in every cycle in
// which in_ch.valid is high and the skid stage is empty; its result is
// registered in the result register, or in the skid entry while an earlier
// result waits. The keystream, position and mark state update in the cycle
// of acceptance; the xorshift step in the keystream unit is combinational.
// A result register plus one skid entry lets a new item enter while an
// earlier result waits for out_ch.ready. After an item flagged
// end_of_message, the generator seeds, position and mark index return to
// their reset values, ready for the next message. No clearing pass after reset.
`default_nettype none
module layered_xor_stream_cipher_core (
  input  wire logic clk,
  input  wire logic rst_n,
  lxsc_in_if.sink   in_ch,
  lxsc_out_if.source out_ch
);

  // handshake
  logic               in_fire;
  logic               out_pop;
  lxsc_pkg::ks_ctrl_t ks_ctrl;
  logic [7:0]         pad_byte;
  logic [7:0]         new_byte;

  // result register and skid entry
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [7:0] out_byte_nxt;
  logic       out_final_r;
  logic       out_final_nxt;
  logic       skid_valid_r;
  logic       skid_valid_nxt;
  logic [7:0] skid_byte_r;
  logic [7:0] skid_byte_nxt;
  logic       skid_final_r;
  logic       skid_final_nxt;

  // take items while the skid entry is free
  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign out_pop     = out_valid_r && out_ch.ready;

  assign ks_ctrl.advance = in_fire;
  assign ks_ctrl.last    = in_ch.end_of_message;

  lxsc_keystream u_ks (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ks_ctrl),
    .pad_byte (pad_byte)
  );

  // all four xor layers for the current item
  assign new_byte = in_ch.data_byte ^ in_ch.key_byte ^ pad_byte;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_final_nxt  = out_final_r;
    skid_valid_nxt = skid_valid_r;
    skid_byte_nxt  = skid_byte_r;
    skid_final_nxt = skid_final_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (out_pop && skid_valid_r) begin
      // drain the skid entry into the result register
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = skid_byte_r;
      out_final_nxt  = skid_final_r;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = new_byte;
        out_final_nxt = in_ch.end_of_message;
      end else begin
        // result still waiting: park the new item
        skid_valid_nxt = 1'b1;
        skid_byte_nxt  = new_byte;
        skid_final_nxt = in_ch.end_of_message;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_final_r  <= out_final_nxt;
    skid_byte_r  <= skid_byte_nxt;
    skid_final_r <= skid_final_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_byte = out_byte_r;
  assign out_ch.final_out   = out_final_r;

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty result register");
  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && out_valid_r && !out_ch.ready |=> skid_valid_r)
    else $error("item accepted during stall was not parked");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ch.ready |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not drained");
`endif

endmodule
`default_nettype wire

// ----- src/lxsc_keystream.sv -----
// module: xorshift keystream, position and mark index state, per-position pad byte
`default_nettype none
module lxsc_keystream (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lxsc_pkg::ks_ctrl_t ctrl,
  output logic [7:0]              pad_byte
);

  logic [31:0] w_r   [4];
  logic [31:0] w_nxt [4];
  logic [7:0]  pos_r;
  logic [7:0]  pos_nxt;
  logic [3:0]  mark_r;
  logic [3:0]  mark_nxt;

  logic        step;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w0_step;
  logic [7:0]  ks;
  logic [15:0] pos_prod;

  assign step    = (pos_r[3:0] == 4'd0);
  assign t1      = w_r[3] ^ (w_r[3] << 11);
  assign t2      = t1 ^ (t1 >> 8);
  assign w0_step = w_r[0] ^ (w_r[0] >> 19) ^ t2 ^ (t2 >> 8);
  assign pos_prod = {8'd0, pos_r} * {8'd0, lxsc_pkg::PosMult};

  always_comb begin
    if (step) begin
      ks = w0_step[15:8];
    end else begin
      case (pos_r[1:0])
        2'd0:    ks = w_r[0][7:0];
        2'd1:    ks = w_r[0][15:8];
        2'd2:    ks = w_r[0][23:16];
        default: ks = w_r[0][31:24];
      endcase
    end
  end

  assign pad_byte = ks ^ lxsc_pkg::mark_byte(mark_r) ^ pos_prod[7:0];

  always_comb begin
    w_nxt    = w_r;
    pos_nxt  = pos_r;
    mark_nxt = mark_r;
    if (ctrl.advance) begin
      if (ctrl.last) begin
        w_nxt[0] = lxsc_pkg::SeedW0;
        w_nxt[1] = lxsc_pkg::SeedW1;
        w_nxt[2] = lxsc_pkg::SeedW2;
        w_nxt[3] = lxsc_pkg::SeedW3;
        pos_nxt  = 8'd0;
        mark_nxt = 4'd0;
      end else begin
        if (step) begin
          w_nxt[0] = w0_step;
          w_nxt[1] = w_r[0];
          w_nxt[2] = w_r[1];
          w_nxt[3] = w_r[2];
        end
        pos_nxt  = pos_r + 8'd1;
        mark_nxt = (mark_r >= lxsc_pkg::MarkLast) ? 4'd0 : mark_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r[0] <= lxsc_pkg::SeedW0;
      w_r[1] <= lxsc_pkg::SeedW1;
      w_r[2] <= lxsc_pkg::SeedW2;
      w_r[3] <= lxsc_pkg::SeedW3;
      pos_r  <= 8'd0;
      mark_r <= 4'd0;
    end else begin
      w_r    <= w_nxt;
      pos_r  <= pos_nxt;
      mark_r <= mark_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && ctrl.last |=> pos_r == 8'd0 && mark_r == 4'd0 &&
                                  w_r[0] == lxsc_pkg::SeedW0)
    else $error("state not cleared after final item");
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= lxsc_pkg::MarkLast)
    else $error("mark index out of range");
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && !ctrl.last |=> pos_r == $past(pos_r) + 8'd1)
    else $error("position did not advance");
`endif

endmodule
`default_nettype wire
